// ===== rtl/dataflow_issue_window_defines.svh =====
// Assertion macros used by the issue window top level.
`ifndef DATAFLOW_ISSUE_WINDOW_DEFINES_SVH
`define DATAFLOW_ISSUE_WINDOW_DEFINES_SVH

`ifndef SYNTH

`define DFIW_ASSERT(label, clk_s, rstn_s, prop) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("issue window check failed");

`define DFIW_ASSERT_NEVER(label, clk_s, rstn_s, expr) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) !(expr)) \
    else $error("issue window forbidden condition");

`else

`define DFIW_ASSERT(label, clk_s, rstn_s, prop)

`define DFIW_ASSERT_NEVER(label, clk_s, rstn_s, expr)

`endif

`endif

// ===== rtl/dfiw_pkg.sv =====
// Types, constants and helper functions of the issue window.
package dfiw_pkg;

  localparam int WINDOW_DEPTH = 16;
  localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int REG_W        = 8;
  localparam int LAT_W        = 8;
  localparam int TICK_W       = 32;
  localparam int LIMIT_W      = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [REG_W-1:0] dest_reg;
    logic [REG_W-1:0] src_a_reg;
    logic [REG_W-1:0] src_b_reg;
    logic [LAT_W-1:0] exec_latency;
  } item_t;

  typedef struct packed {
    logic              accepted;
    logic [CNT_W-1:0]  retired_count;
    logic [CNT_W-1:0]  occupancy;
    logic [TICK_W-1:0] tick_count;
  } result_t;

  typedef struct packed {
    logic item_vld;
    logic fire;
  } flow_t;

  function automatic logic [SLOT_W-1:0] onehot_to_idx(input logic [WINDOW_DEPTH-1:0] oh);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      if (oh[i]) begin
        idx = idx | SLOT_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [CNT_W-1:0] pop_count(input logic [WINDOW_DEPTH-1:0] vec);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      n = n + CNT_W'(vec[i]);
    end
    return n;
  endfunction

endpackage

// ===== rtl/dfiw_in_stage.sv =====
// Input register that holds one item until the window processes it.
module dfiw_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dfiw_pkg::item_t    in_item,
  input  logic               fire,
  output logic               item_vld,
  output dfiw_pkg::item_t    item
);

  logic            vld_r, vld_nxt;
  dfiw_pkg::item_t item_r, item_nxt;
  logic            accept;

  assign in_stall = vld_r & ~fire;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    vld_nxt  = vld_r;
    item_nxt = item_r;
    if (accept) begin
      vld_nxt  = 1'b1;
      item_nxt = in_item;
    end else if (fire) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

// ===== rtl/dfiw_window.sv =====
// Entry file with producer lookup, wakeup, countdown and retirement.
module dfiw_window (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [dfiw_pkg::LIMIT_W-1:0]    cfg_wr_data,
  input  logic                            fire,
  input  dfiw_pkg::item_t                 item,
  output dfiw_pkg::result_t               result
);

  localparam int D = dfiw_pkg::WINDOW_DEPTH;

  logic [dfiw_pkg::LIMIT_W-1:0] limit_r;
  logic [dfiw_pkg::CNT_W-1:0]   occ_r, occ_nxt;
  logic [dfiw_pkg::TICK_W-1:0]  ticks_r, ticks_nxt;
  logic [D-1:0]                 valid_r, valid_nxt;
  logic [D-1:0]                 wa_r, wa_nxt, wb_r, wb_nxt;
  logic [dfiw_pkg::REG_W-1:0]   dest_r [D];
  logic [dfiw_pkg::REG_W-1:0]   dest_nxt [D];
  logic [dfiw_pkg::LAT_W-1:0]   rem_r [D];
  logic [dfiw_pkg::LAT_W-1:0]   rem_nxt [D];
  logic [dfiw_pkg::SLOT_W-1:0]  wa_slot_r [D];
  logic [dfiw_pkg::SLOT_W-1:0]  wa_slot_nxt [D];
  logic [dfiw_pkg::SLOT_W-1:0]  wb_slot_r [D];
  logic [dfiw_pkg::SLOT_W-1:0]  wb_slot_nxt [D];
  // A set bit at row i, column j means entry i was inserted before entry j.
  logic [D-1:0]                 older_r [D];
  logic [D-1:0]                 older_nxt [D];

  logic [dfiw_pkg::CNT_W-1:0]   limit;
  logic                         is_tick, ins_ok;
  logic [D-1:0]                 free_vec, free_oh;
  logic [dfiw_pkg::SLOT_W-1:0]  free_idx;
  logic [D-1:0]                 match_a, match_b, young_a, young_b;
  logic [dfiw_pkg::SLOT_W-1:0]  prod_a, prod_b;
  logic [D-1:0]                 ready, retire, valid_after;
  logic [dfiw_pkg::CNT_W-1:0]   retired_cnt;

  assign limit = (limit_r > dfiw_pkg::CNT_W'(D)) ? dfiw_pkg::CNT_W'(D) : limit_r;
  assign is_tick = (item.operation == dfiw_pkg::OP_TICK);
  assign ins_ok  = !is_tick && (occ_r < limit);

  assign free_vec = ~valid_r;
  assign free_oh  = free_vec & (~free_vec + D'(1));
  assign free_idx = dfiw_pkg::onehot_to_idx(free_oh);

  always_comb begin
    for (int i = 0; i < D; i++) begin
      match_a[i] = valid_r[i] && (dest_r[i] == item.src_a_reg);
      match_b[i] = valid_r[i] && (dest_r[i] == item.src_b_reg);
    end
    for (int i = 0; i < D; i++) begin
      young_a[i] = match_a[i] && !(|(match_a & older_r[i]));
      young_b[i] = match_b[i] && !(|(match_b & older_r[i]));
    end
  end

  assign prod_a = dfiw_pkg::onehot_to_idx(young_a);
  assign prod_b = dfiw_pkg::onehot_to_idx(young_b);

  always_comb begin
    for (int i = 0; i < D; i++) begin
      ready[i]  = valid_r[i] && !wa_r[i] && !wb_r[i];
      retire[i] = ready[i] && (rem_r[i] <= dfiw_pkg::LAT_W'(1));
    end
  end

  assign valid_after = valid_r & ~retire;
  assign retired_cnt = dfiw_pkg::pop_count(retire);

  always_comb begin
    valid_nxt = valid_r;
    wa_nxt    = wa_r;
    wb_nxt    = wb_r;
    occ_nxt   = occ_r;
    ticks_nxt = ticks_r;
    for (int i = 0; i < D; i++) begin
      dest_nxt[i]    = dest_r[i];
      rem_nxt[i]     = rem_r[i];
      wa_slot_nxt[i] = wa_slot_r[i];
      wb_slot_nxt[i] = wb_slot_r[i];
      older_nxt[i]   = older_r[i];
    end
    if (fire) begin
      if (is_tick) begin
        ticks_nxt = ticks_r + dfiw_pkg::TICK_W'(1);
        occ_nxt   = occ_r - retired_cnt;
        valid_nxt = valid_after;
        for (int i = 0; i < D; i++) begin
          if (ready[i] && !retire[i]) begin
            rem_nxt[i] = rem_r[i] - dfiw_pkg::LAT_W'(1);
          end
          if (valid_after[i]) begin
            wa_nxt[i] = wa_r[i] && valid_after[wa_slot_r[i]];
            wb_nxt[i] = wb_r[i] && valid_after[wb_slot_r[i]];
          end
        end
      end else if (ins_ok) begin
        occ_nxt             = occ_r + dfiw_pkg::CNT_W'(1);
        valid_nxt[free_idx] = 1'b1;
        wa_nxt[free_idx]    = |match_a;
        wb_nxt[free_idx]    = |match_b;
        dest_nxt[free_idx]    = item.dest_reg;
        rem_nxt[free_idx]     = item.exec_latency;
        wa_slot_nxt[free_idx] = prod_a;
        wb_slot_nxt[free_idx] = prod_b;
        for (int k = 0; k < D; k++) begin
          older_nxt[k][free_idx] = (k != int'(free_idx));
        end
        older_nxt[free_idx] = '0;
      end
    end
  end

  always_comb begin
    result.accepted      = ins_ok;
    result.retired_count = is_tick ? retired_cnt : '0;
    result.occupancy     = occ_nxt;
    result.tick_count    = is_tick ? (ticks_r + dfiw_pkg::TICK_W'(1)) : ticks_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= dfiw_pkg::LIMIT_RESET;
      occ_r   <= '0;
      ticks_r <= '0;
      valid_r <= '0;
      wa_r    <= '0;
      wb_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      occ_r   <= occ_nxt;
      ticks_r <= ticks_nxt;
      valid_r <= valid_nxt;
      wa_r    <= wa_nxt;
      wb_r    <= wb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < D; i++) begin
      dest_r[i]    <= dest_nxt[i];
      rem_r[i]     <= rem_nxt[i];
      wa_slot_r[i] <= wa_slot_nxt[i];
      wb_slot_r[i] <= wb_slot_nxt[i];
      older_r[i]   <= older_nxt[i];
    end
  end

endmodule

// ===== rtl/dfiw_out_stage.sv =====
// Result register that holds one result item until the receiver takes it.
module dfiw_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_vld,
  output dfiw_pkg::flow_t     flow,
  input  dfiw_pkg::result_t   result,
  output logic                out_valid,
  input  logic                out_stall,
  output dfiw_pkg::result_t   out_result
);

  logic              vld_r, vld_nxt;
  dfiw_pkg::result_t res_r, res_nxt;
  logic              load_ok;

  assign load_ok       = ~vld_r | ~out_stall;
  assign flow.item_vld = item_vld;
  assign flow.fire     = item_vld & load_ok;

  always_comb begin
    vld_nxt = vld_r & out_stall;
    res_nxt = res_r;
    if (flow.fire) begin
      vld_nxt = 1'b1;
      res_nxt = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid  = vld_r;
  assign out_result = res_r;

endmodule

// ===== rtl/dataflow_issue_window.sv =====
// Top level of the out-of-order issue window with dataflow wakeup.
//
//   channel   direction   handshake              payload
//   in_       in          in_valid / in_stall    operation, regs, latency
//   out_      out         out_valid / out_stall  accepted, retired, occupancy, ticks
//   cfg_      in          cfg_wr_en              cfg_wr_data (window limit)
//
// Each item is held in the input register and is resolved against the entry
// file in the cycle that loads the result register, so one item per cycle is
// sustained while the result side does not stall.
// Reset is synchronous and active low; it empties the window and clears ticks.
// A stall on the result side holds the result register and then the input register.
`include "dataflow_issue_window_defines.svh"

module dataflow_issue_window (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [dfiw_pkg::LIMIT_W-1:0]    cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_operation,
  input  logic [dfiw_pkg::REG_W-1:0]      in_dest_reg,
  input  logic [dfiw_pkg::REG_W-1:0]      in_src_a_reg,
  input  logic [dfiw_pkg::REG_W-1:0]      in_src_b_reg,
  input  logic [dfiw_pkg::LAT_W-1:0]      in_exec_latency,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_accepted,
  output logic [dfiw_pkg::CNT_W-1:0]      out_retired_count,
  output logic [dfiw_pkg::CNT_W-1:0]      out_occupancy,
  output logic [dfiw_pkg::TICK_W-1:0]     out_tick_count
);

  dfiw_pkg::item_t   in_item, item;
  dfiw_pkg::result_t result, out_result;
  dfiw_pkg::flow_t   flow;
  logic              item_vld;

  assign in_item.operation    = in_operation;
  assign in_item.dest_reg     = in_dest_reg;
  assign in_item.src_a_reg    = in_src_a_reg;
  assign in_item.src_b_reg    = in_src_b_reg;
  assign in_item.exec_latency = in_exec_latency;

  dfiw_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .fire     (flow.fire),
    .item_vld (item_vld),
    .item     (item)
  );

  dfiw_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (flow.fire),
    .item        (item),
    .result      (result)
  );

  dfiw_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_vld   (item_vld),
    .flow       (flow),
    .result     (result),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign out_accepted      = out_result.accepted;
  assign out_retired_count = out_result.retired_count;
  assign out_occupancy     = out_result.occupancy;
  assign out_tick_count    = out_result.tick_count;

  `DFIW_ASSERT(a_occ_bound, clk, rst_n, out_valid |-> (out_occupancy <= dfiw_pkg::CNT_W'(dfiw_pkg::WINDOW_DEPTH)))
  `DFIW_ASSERT(a_insert_no_retire, clk, rst_n, (out_valid && out_accepted) |-> (out_retired_count == '0))
  `DFIW_ASSERT(a_fire_to_result, clk, rst_n, flow.fire |=> out_valid)
  `DFIW_ASSERT_NEVER(a_stall_when_empty, clk, rst_n, in_stall && !flow.item_vld)

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the dataflow issue window: directed table, then random phases.
`timescale 1ns / 100ps

module tb_top;
  import dfiw_pkg::*;

  localparam int IDLE_LIMIT = 1000;

  typedef struct {
    bit                 set_cfg;
    logic [LIMIT_W-1:0] cfg_val;
    item_t              it;
    bit                 typed;
    result_t            want;
  } opening_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [LIMIT_W-1:0] cfg_wr_data;
  logic in_valid;
  logic in_stall;
  logic in_operation;
  logic [REG_W-1:0] in_dest_reg;
  logic [REG_W-1:0] in_src_a_reg;
  logic [REG_W-1:0] in_src_b_reg;
  logic [LAT_W-1:0] in_exec_latency;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_accepted;
  logic [CNT_W-1:0] out_retired_count;
  logic [CNT_W-1:0] out_occupancy;
  logic [TICK_W-1:0] out_tick_count;

  logic [WINDOW_DEPTH-1:0] win_valid;
  logic [WINDOW_DEPTH-1:0] wa_flag;
  logic [WINDOW_DEPTH-1:0] wb_flag;
  logic [REG_W-1:0] win_dest [WINDOW_DEPTH];
  logic [LAT_W-1:0] win_left [WINDOW_DEPTH];
  logic [15:0] win_age [WINDOW_DEPTH];
  logic [SLOT_W-1:0] wa_slot [WINDOW_DEPTH];
  logic [SLOT_W-1:0] wb_slot [WINDOW_DEPTH];
  logic [15:0] age_ctr;
  logic [TICK_W-1:0] tick_ctr;
  logic [LIMIT_W-1:0] limit_reg;

  result_t outcome_q [$];
  opening_row_t opening_rows [14];
  int mismatches = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  dataflow_issue_window dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_dest_reg      (in_dest_reg),
    .in_src_a_reg     (in_src_a_reg),
    .in_src_b_reg     (in_src_b_reg),
    .in_exec_latency  (in_exec_latency),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_retired_count(out_retired_count),
    .out_occupancy    (out_occupancy),
    .out_tick_count   (out_tick_count)
  );

  always #5 clk = ~clk;

  function automatic bit youngest_writer(input logic [REG_W-1:0] rg,
                                         output logic [SLOT_W-1:0] slot);
    bit found;
    logic [15:0] best;
    logic [15:0] gap;
    found = 1'b0;
    best = '0;
    slot = '0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      if (win_valid[i] && win_dest[i] == rg) begin
        gap = age_ctr - win_age[i];
        if (!found || gap < best) begin
          found = 1'b1;
          best = gap;
          slot = SLOT_W'(i);
        end
      end
    end
    return found;
  endfunction

  function automatic result_t advance_window(input item_t it);
    result_t r;
    logic [WINDOW_DEPTH-1:0] ready;
    int lim;
    int slot;
    r = '0;
    if (it.operation == OP_INSERT) begin
      lim = (limit_reg > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(limit_reg);
      if ($countones(win_valid) < lim) begin
        slot = 0;
        for (int i = WINDOW_DEPTH - 1; i >= 0; i--) begin
          if (!win_valid[i]) slot = i;
        end
        wa_flag[slot] = youngest_writer(it.src_a_reg, wa_slot[slot]);
        wb_flag[slot] = youngest_writer(it.src_b_reg, wb_slot[slot]);
        win_dest[slot] = it.dest_reg;
        win_left[slot] = it.exec_latency;
        win_age[slot] = age_ctr;
        age_ctr = age_ctr + 16'd1;
        win_valid[slot] = 1'b1;
        r.accepted = 1'b1;
      end
    end else begin
      ready = win_valid & ~wa_flag & ~wb_flag;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        if (ready[i]) begin
          if (win_left[i] > 1) begin
            win_left[i] = win_left[i] - 1'b1;
          end else begin
            win_valid[i] = 1'b0;
            r.retired_count = r.retired_count + 1'b1;
          end
        end
      end
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        if (win_valid[i]) begin
          if (wa_flag[i] && !win_valid[wa_slot[i]]) wa_flag[i] = 1'b0;
          if (wb_flag[i] && !win_valid[wb_slot[i]]) wb_flag[i] = 1'b0;
        end
      end
      tick_ctr = tick_ctr + 1'b1;
    end
    r.occupancy = CNT_W'($countones(win_valid));
    r.tick_count = tick_ctr;
    return r;
  endfunction

  function automatic logic [REG_W-1:0] pick_reg();
    return ($urandom_range(9) < 8) ? REG_W'($urandom_range(7)) : REG_W'($urandom_range(255));
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 50) begin
      $display("tb_top: %s mismatch, got %0d expected %0d at %0t", what, got, want, $realtime);
    end
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] v);
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    limit_reg = v;
  endtask

  task automatic send_item(input item_t it, input bit typed, input result_t want);
    result_t guess;
    while (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= it.operation;
    in_dest_reg <= it.dest_reg;
    in_src_a_reg <= it.src_a_reg;
    in_src_b_reg <= it.src_b_reg;
    in_exec_latency <= it.exec_latency;
    do @(posedge clk); while (in_stall);
    guess = advance_window(it);
    if (typed) guess = want;
    outcome_q = {outcome_q, guess};
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 15);
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("unexpected result", out_occupancy, 0);
      end else begin
        want = outcome_q.pop_front();
        if (out_accepted !== want.accepted)
          report_mismatch("accepted", out_accepted, want.accepted);
        if (out_retired_count !== want.retired_count)
          report_mismatch("retired_count", out_retired_count, want.retired_count);
        if (out_occupancy !== want.occupancy)
          report_mismatch("occupancy", out_occupancy, want.occupancy);
        if (out_tick_count !== want.tick_count)
          report_mismatch("tick_count", out_tick_count, want.tick_count);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    item_t it;
    result_t none;
    logic [LIMIT_W-1:0] phase_lim [8];
    int ins_pct;
    int n_items;
    none = '0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_operation = OP_INSERT;
    in_dest_reg = '0;
    in_src_a_reg = '0;
    in_src_b_reg = '0;
    in_exec_latency = '0;
    win_valid = '0;
    wa_flag = '0;
    wb_flag = '0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      win_dest[i] = '0;
      win_left[i] = '0;
      win_age[i] = '0;
      wa_slot[i] = '0;
      wb_slot[i] = '0;
    end
    age_ctr = '0;
    tick_ctr = '0;
    limit_reg = LIMIT_RESET;
    phase_lim = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd7, 5'd16, 5'd2, 5'd20};
    opening_rows = '{
      '{1'b0, 5'd0,  '{OP_TICK,   8'd0,   8'd0,   8'd0,   8'd0},   1'b1, '{1'b0, 5'd0, 5'd0, 32'd1}},
      '{1'b0, 5'd0,  '{OP_INSERT, 8'd0,   8'd0,   8'd0,   8'd0},   1'b1, '{1'b1, 5'd0, 5'd1, 32'd1}},
      '{1'b0, 5'd0,  '{OP_INSERT, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1, '{1'b1, 5'd0, 5'd2, 32'd1}},
      '{1'b0, 5'd0,  '{OP_INSERT, 8'd5,   8'd0,   8'd255, 8'd1},   1'b1, '{1'b1, 5'd0, 5'd3, 32'd1}},
      '{1'b0, 5'd0,  '{OP_TICK,   8'd255, 8'd255, 8'd255, 8'd255}, 1'b1, '{1'b0, 5'd1, 5'd2, 32'd2}},
      '{1'b0, 5'd0,  '{OP_INSERT, 8'd255, 8'd255, 8'd0,   8'd2},   1'b0, '{1'b0, 5'd0, 5'd0, 32'd0}},
      '{1'b0, 5'd0,  '{OP_INSERT, 8'd7,   8'd255, 8'd5,   8'd3},   1'b0, '{1'b0, 5'd0, 5'd0, 32'd0}},
      '{1'b0, 5'd0,  '{OP_TICK,   8'd0,   8'd0,   8'd0,   8'd0},   1'b0, '{1'b0, 5'd0, 5'd0, 32'd0}},
      '{1'b1, 5'd0,  '{OP_INSERT, 8'd1,   8'd2,   8'd3,   8'd4},   1'b1, '{1'b0, 5'd0, 5'd4, 32'd3}},
      '{1'b1, 5'd4,  '{OP_INSERT, 8'd1,   8'd2,   8'd3,   8'd4},   1'b1, '{1'b0, 5'd0, 5'd4, 32'd3}},
      '{1'b1, 5'd31, '{OP_INSERT, 8'd9,   8'd9,   8'd9,   8'd1},   1'b0, '{1'b0, 5'd0, 5'd0, 32'd0}},
      '{1'b1, 5'd1,  '{OP_INSERT, 8'd9,   8'd170, 8'd85,  8'd170}, 1'b0, '{1'b0, 5'd0, 5'd0, 32'd0}},
      '{1'b1, 5'd16, '{OP_TICK,   8'd0,   8'd0,   8'd0,   8'd0},   1'b0, '{1'b0, 5'd0, 5'd0, 32'd0}},
      '{1'b0, 5'd0,  '{OP_INSERT, 8'd85,  8'd170, 8'd85,  8'd0},   1'b0, '{1'b0, 5'd0, 5'd0, 32'd0}}
    };
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[i]) begin
      if (opening_rows[i].set_cfg) set_limit(opening_rows[i].cfg_val);
      send_item(opening_rows[i].it, opening_rows[i].typed, opening_rows[i].want);
    end

    for (int p = 0; p < 8; p++) begin
      set_limit(phase_lim[p]);
      calm = (p == 2);
      ins_pct = $urandom_range(65, 40);
      n_items = (phase_lim[p] == 0) ? 40 : 270;
      for (int n = 0; n < n_items; n++) begin
        it.operation = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_TICK;
        it.dest_reg = pick_reg();
        it.src_a_reg = pick_reg();
        it.src_b_reg = pick_reg();
        it.exec_latency = ($urandom_range(99) == 0) ? LAT_W'($urandom_range(255))
                                                    : LAT_W'($urandom_range(5));
        send_item(it, 1'b0, none);
      end
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
